// ----- sv/frma_pkg.sv -----
// Package for the moving-average frame rate meter.
// Shared widths, register indexes, reset values and divider status type.
// No dependencies.
`default_nettype none

package frma_pkg;

  localparam int RATE_W     = 32;
  localparam int TICK_W     = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int WINDOW_DEFAULT = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL  = 1'd1;

  localparam logic [TICK_W-1:0] TPS_RESET      = 32'd1000000;
  localparam logic [TICK_W-1:0] INTERVAL_RESET = 32'd16667;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ----- sv/frma_rate_div.sv -----
// Bit-serial divider for the instantaneous rate: ticks_per_second*256/interval.
// One quotient bit per cycle, saturates on zero divisor or overflow.
// Depends on frma_pkg.
`default_nettype none

module frma_rate_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [frma_pkg::TICK_W-1:0]  tps,
  input  wire logic [frma_pkg::TICK_W-1:0]  interval,
  output frma_pkg::div_stat_t               stat,
  output logic      [frma_pkg::RATE_W-1:0]  quot
);
  import frma_pkg::*;

  logic [TICK_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] quo_r, quo_nxt;
  logic [TICK_W-1:0] dvs_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic [TICK_W:0]   trial;
  logic [TICK_W:0]   diff;
  logic              ge;
  logic              sat;

  // quotient reaches 2^32 exactly when tps >> 24 is not below the interval
  assign sat   = (interval == '0) || ({24'd0, tps[31:24]} >= interval);
  assign trial = {rem_r, quo_r[RATE_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt = ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
    quo_nxt = {quo_r[RATE_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (sat) begin
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= {24'd0, tps[31:24]};
          quo_r  <= {tps[23:0], 8'd0};
          dvs_r  <= interval;
          cnt_r  <= 6'd32;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule

`default_nettype wire

// ----- sv/frma_avg_div.sv -----
// Bit-serial divider of the running sum by the window length.
// Narrow remainder, one quotient bit per cycle.
// Depends on frma_pkg.
`default_nettype none

module frma_avg_div #(
  parameter int WINDOW = frma_pkg::WINDOW_DEFAULT,
  parameter int SUM_W  = 32 + $clog2(WINDOW)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [SUM_W-1:0]             sum,
  output frma_pkg::div_stat_t               stat,
  output logic      [frma_pkg::RATE_W-1:0]  quot
);
  import frma_pkg::*;

  localparam int REM_W = $clog2(WINDOW + 1);
  localparam int CW    = $clog2(SUM_W + 1);
  localparam logic [REM_W:0] WIN_C = (REM_W+1)'(WINDOW);

  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [SUM_W-1:0] sh_r, sh_nxt;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [REM_W:0]   trial, diff;
  logic             ge;

  assign trial = {rem_r, sh_r[SUM_W-1]};
  assign diff  = trial - WIN_C;
  assign ge    = trial >= WIN_C;

  always_comb begin
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    sh_nxt  = {sh_r[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        sh_r   <= sum;
        cnt_r  <= CW'(SUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= sh_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = sh_r[RATE_W-1:0];

endmodule

`default_nettype wire

// ----- sv/frma_ring.sv -----
// Window ring of rates: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on frma_pkg.
`default_nettype none

module frma_ring #(
  parameter int WINDOW = frma_pkg::WINDOW_DEFAULT,
  parameter int PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [PTR_W-1:0]             raddr,
  input  wire logic                         wr_en,
  input  wire logic [PTR_W-1:0]             waddr,
  input  wire logic [frma_pkg::RATE_W-1:0]  wdata,
  output logic      [frma_pkg::RATE_W-1:0]  rdata
);
  import frma_pkg::*;

  logic [RATE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0] vld_r;
  logic [RATE_W-1:0] q_r;
  logic              qv_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[waddr] <= 1'b1;
      end
      if (rd_en) begin
        qv_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = qv_r ? q_r : '0;

endmodule

`default_nettype wire

// ----- sv/frame_rate_moving_average_unit.sv -----
// Moving-average frame rate meter: sequencer, state registers and result stage.
// Instantiates frma_rate_div, frma_ring and frma_avg_div; depends on frma_pkg.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_stall     frame_interval_ticks, timestamp_ticks
//   out_     output     out_valid / out_stall   average_rate_q8, sample_taken, samples_total
//   cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// A rejected frame yields its item in the cycle after acceptance; a new item can be taken
// once the output is not stalled. An accepted sample passes through the bit-serial rate
// divider (which skips its bit-serial pass when the rate saturates), the running-sum
// update, the divide-by-window unit with one quotient bit per sum bit, and the output push.
// Synchronous reset clears the ring through valid bits; no clearing pass.
// A stalled result holds in the output register and blocks further input.
`default_nettype none

module frame_rate_moving_average_unit #(
  parameter int WINDOW = frma_pkg::WINDOW_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [frma_pkg::TICK_W-1:0]      in_frame_interval_ticks,
  input  wire logic [frma_pkg::TICK_W-1:0]      in_timestamp_ticks,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [frma_pkg::RATE_W-1:0]      out_average_rate_q8,
  output logic                                  out_sample_taken,
  output logic      [frma_pkg::CNT_W-1:0]       out_samples_total,
  input  wire logic                             cfg_we,
  input  wire logic [frma_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frma_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import frma_pkg::*;

  localparam int SUM_W = 32 + $clog2(WINDOW);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW) * SUM_W'(33'h0_FFFF_FFFF);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RATE = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_AVG  = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0]        state_r;
  logic [TICK_W-1:0] tps_r, intv_r;
  logic [TICK_W-1:0] last_r;
  logic [CNT_W-1:0]  count_r;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [SUM_W-1:0]  sum_r, sum_add;
  logic [RATE_W-1:0] rate_r, avg_r;
  logic [TICK_W-1:0] elapsed;
  logic              taken;
  logic              in_acc, out_free;

  logic              out_valid_r, out_taken_r;
  logic [RATE_W-1:0] out_avg_r;
  logic [CNT_W-1:0]  out_cnt_r;

  div_stat_t         rate_stat, avg_stat;
  logic [RATE_W-1:0] rate_q, avg_q, old_rate;
  logic              rate_start, avg_start;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == S_IDLE && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign elapsed  = in_timestamp_ticks - last_r;
  assign taken    = elapsed > intv_r;
  assign ptr_nxt  = (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : PTR_W'(ptr_r + 1'b1);
  assign sum_add  = sum_r + {{(SUM_W-RATE_W){1'b0}}, rate_r};

  assign rate_start = in_acc && taken;
  assign avg_start  = (state_r == S_ADD);

  frma_rate_div u_rate_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rate_start),
    .tps      (tps_r),
    .interval (in_frame_interval_ticks),
    .stat     (rate_stat),
    .quot     (rate_q)
  );

  frma_ring #(
    .WINDOW (WINDOW),
    .PTR_W  (PTR_W)
  ) u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (rate_start),
    .raddr (ptr_nxt),
    .wr_en (state_r == S_ADD),
    .waddr (ptr_r),
    .wdata (rate_r),
    .rdata (old_rate)
  );

  frma_avg_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_avg_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (avg_start),
    .sum   (sum_add),
    .stat  (avg_stat),
    .quot  (avg_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r  <= TPS_RESET;
      intv_r <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_r  <= cfg_wdata;
        CFG_SAMPLE_INTERVAL:  intv_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (taken) begin
              last_r  <= in_timestamp_ticks;
              ptr_r   <= ptr_nxt;
              count_r <= CNT_W'(count_r + 1'b1);
              state_r <= S_RATE;
            end else begin
              out_valid_r <= 1'b1;
              out_avg_r   <= avg_r;
              out_taken_r <= 1'b0;
              out_cnt_r   <= count_r;
            end
          end
        end
        S_RATE: begin
          if (rate_stat.done) begin
            rate_r  <= rate_q;
            sum_r   <= sum_r - {{(SUM_W-RATE_W){1'b0}}, old_rate};
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          sum_r   <= sum_add;
          state_r <= S_AVG;
        end
        S_AVG: begin
          if (avg_stat.done) begin
            avg_r   <= avg_q;
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_avg_r   <= avg_r;
            out_taken_r <= 1'b1;
            out_cnt_r   <= count_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_average_rate_q8 = out_avg_r;
  assign out_sample_taken    = out_taken_r;
  assign out_samples_total   = out_cnt_r;

  a_rate_done_in_rate: assert property (@(posedge clk) disable iff (!rst_n)
    rate_stat.done |-> state_r == S_RATE)
    else $error("rate divider finished outside its wait state");

  a_avg_done_in_avg: assert property (@(posedge clk) disable iff (!rst_n)
    avg_stat.done |-> state_r == S_AVG)
    else $error("average divider finished outside its wait state");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_MAX)
    else $error("running sum exceeds window capacity");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(WINDOW - 1))
    else $error("ring pointer out of range");

  a_push_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUSH && out_free) |=> out_valid_r && out_taken_r)
    else $error("accepted sample did not produce a taken item");

endmodule

`default_nettype wire
